@@ design/dsms_pkg.sv @@
package dsms_pkg;

  localparam int unsigned DistW    = 10;
  localparam int unsigned ValW     = 7;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ValW-1:0] ClampAbove = 7'd95;
  localparam logic [ValW-1:0] ClampValue = 7'd100;
  localparam logic [ValW-1:0] RampStep   = 7'd2;
  localparam logic [ValW-1:0] SpeedMax   = 7'd127;

  localparam logic [ValW-1:0] HighDistRst  = 7'd50;
  localparam logic [ValW-1:0] LowDistRst   = 7'd20;
  localparam logic [ValW-1:0] HighSpeedRst = 7'd90;
  localparam logic [ValW-1:0] LowSpeedRst  = 7'd40;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_LOW  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STEER_NONE  = 2'd0,
    STEER_FWD   = 2'd1,
    STEER_RIGHT = 2'd2,
    STEER_LEFT  = 2'd3
  } steer_e;

  typedef enum logic [1:0] {
    REG_HIGH_DIST  = 2'd0,
    REG_LOW_DIST   = 2'd1,
    REG_HIGH_SPEED = 2'd2,
    REG_LOW_SPEED  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ValW-1:0] high_distance;
    logic [ValW-1:0] low_distance;
    logic [ValW-1:0] high_speed;
    logic [ValW-1:0] low_speed;
  } cfg_t;

  typedef struct packed {
    logic [DistW-1:0] distance_cm;
    logic             left_black;
    logic             right_black;
  } item_t;

  typedef struct packed {
    logic [ValW-1:0] motor_speed;
    logic [1:0]      steer_command;
    logic            beep_on;
    logic [1:0]      next_mode;
    logic [ValW-1:0] shown_distance;
  } result_t;

endpackage

@@ design/dsms_in_if.sv @@
interface dsms_in_if;
  import dsms_pkg::*;

  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance_cm;
  logic             left_black;
  logic             right_black;

  modport source (output valid, output distance_cm, output left_black, output right_black,
                  input ready);
  modport sink   (input valid, input distance_cm, input left_black, input right_black,
                  output ready);
endinterface

@@ design/dsms_out_if.sv @@
interface dsms_out_if;
  import dsms_pkg::*;

  logic            valid;
  logic            ready;
  logic [ValW-1:0] motor_speed;
  logic [1:0]      steer_command;
  logic            beep_on;
  logic [1:0]      next_mode;
  logic [ValW-1:0] shown_distance;

  modport source (output valid, output motor_speed, output steer_command, output beep_on,
                  output next_mode, output shown_distance, input ready);
  modport sink   (input valid, input motor_speed, input steer_command, input beep_on,
                  input next_mode, input shown_distance, output ready);
endinterface

@@ design/dsms_core.sv @@
module dsms_core import dsms_pkg::*; (
  input  item_t           item_i,
  input  cfg_t            cfg_i,
  input  mode_e           mode_i,
  input  logic [ValW-1:0] speed_i,
  output mode_e           mode_o,
  output logic [ValW-1:0] speed_o,
  output result_t         result_o
);

  logic [ValW-1:0] dist_clamped;
  logic [ValW:0]   inc;
  logic [ValW-1:0] inc_sat;
  logic            above;
  logic            below;
  logic            band;
  logic            moving;
  steer_e          steer;
  logic            buzz;
  mode_e           next;
  logic [ValW-1:0] speed_nxt;

  always_comb begin
    dist_clamped = (item_i.distance_cm > DistW'(ClampAbove)) ? ClampValue
                                                            : item_i.distance_cm[ValW-1:0];
    inc     = {1'b0, speed_i} + {1'b0, RampStep};
    inc_sat = inc[ValW] ? SpeedMax : inc[ValW-1:0];
    above   = dist_clamped > cfg_i.high_distance;
    below   = dist_clamped < cfg_i.low_distance;
    band    = !above && !below;

    speed_nxt = speed_i;
    steer     = STEER_NONE;
    buzz      = 1'b0;
    next      = mode_i;
    moving    = 1'b1;

    unique case (mode_i)
      MODE_HIGH: begin
        speed_nxt = (speed_i >= cfg_i.high_speed) ? ClampValue : inc_sat;
        if (below) begin
          next = MODE_IDLE;
        end else if (band) begin
          next = MODE_LOW;
        end
      end
      MODE_LOW: begin
        if (speed_i < cfg_i.low_speed) begin
          speed_nxt = inc_sat;
        end else if (speed_i > cfg_i.low_speed) begin
          speed_nxt = speed_i - 7'd1;
        end
        if (above) begin
          next = MODE_HIGH;
        end else if (below) begin
          next = MODE_IDLE;
        end
      end
      default: begin
        // unused mode code falls here and behaves as idle
        moving    = 1'b0;
        speed_nxt = '0;
        buzz      = 1'b1;
        if (item_i.left_black && item_i.right_black) begin
          next = MODE_IDLE;
        end else if (above) begin
          next = MODE_HIGH;
        end else if (band) begin
          next = MODE_LOW;
        end else begin
          next = MODE_IDLE;
        end
      end
    endcase

    if (moving) begin
      unique case ({item_i.left_black, item_i.right_black})
        2'b00: begin
          steer = STEER_FWD;
        end
        2'b10: begin
          steer = STEER_RIGHT;
          buzz  = 1'b1;
        end
        2'b01: begin
          steer = STEER_LEFT;
          buzz  = 1'b1;
        end
        default: begin
          next = MODE_IDLE;
        end
      endcase
    end
  end

  assign mode_o                  = next;
  assign speed_o                 = speed_nxt;
  assign result_o.motor_speed    = speed_nxt;
  assign result_o.steer_command  = steer;
  assign result_o.beep_on        = buzz;
  assign result_o.next_mode      = next;
  assign result_o.shown_distance = dist_clamped;

endmodule

@@ design/distance_speed_mode_steering_unit.sv @@
// Channel | Dir | Port  | Payload
// --------+-----+-------+-----------------------------------------------------------
// input   | in  | in_i  | distance_cm[9:0], left_black, right_black
// result  | out | out_o | motor_speed[6:0], steer_command[1:0], beep_on,
//         |     |       | next_mode[1:0], shown_distance[6:0]
// config  | in  | APB   | four 7-bit registers at byte offsets 0, 4, 8, 12
//
// One item per cycle sustained while the sink takes results; an item passes through the
// input register, then the result register holding the mode/speed update.
// The input register takes one more item while a result waits, so a stalled sink
// backs up the source only after two items are held.
// Reset clears mode to idle, speed to zero and loads the register defaults.
module distance_speed_mode_steering_unit import dsms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  dsms_in_if.sink             in_i,
  dsms_out_if.source          out_o
);

  cfg_t            cfg_q;
  reg_idx_e        reg_idx;
  logic            cfg_wr;
  logic            s1_valid_q;
  item_t           s1_item_q;
  logic            out_valid_q;
  result_t         out_q;
  mode_e           mode_q;
  mode_e           mode_d;
  logic [ValW-1:0] speed_q;
  logic [ValW-1:0] speed_d;
  result_t         result_d;
  logic            advance;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_distance <= HighDistRst;
      cfg_q.low_distance  <= LowDistRst;
      cfg_q.high_speed    <= HighSpeedRst;
      cfg_q.low_speed     <= LowSpeedRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HIGH_DIST:  cfg_q.high_distance <= pwdata[ValW-1:0];
        REG_LOW_DIST:   cfg_q.low_distance  <= pwdata[ValW-1:0];
        REG_HIGH_SPEED: cfg_q.high_speed    <= pwdata[ValW-1:0];
        REG_LOW_SPEED:  cfg_q.low_speed     <= pwdata[ValW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIGH_DIST:  prdata = ApbDataW'(cfg_q.high_distance);
      REG_LOW_DIST:   prdata = ApbDataW'(cfg_q.low_distance);
      REG_HIGH_SPEED: prdata = ApbDataW'(cfg_q.high_speed);
      REG_LOW_SPEED:  prdata = ApbDataW'(cfg_q.low_speed);
      default:        prdata = '0;
    endcase
  end

  // pipeline handshake
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q.distance_cm <= in_i.distance_cm;
      s1_item_q.left_black  <= in_i.left_black;
      s1_item_q.right_black <= in_i.right_black;
    end
  end

  dsms_core u_core (
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .mode_i   (mode_q),
    .speed_i  (speed_q),
    .mode_o   (mode_d),
    .speed_o  (speed_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      speed_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      mode_q      <= mode_d;
      speed_q     <= speed_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.motor_speed    = out_q.motor_speed;
  assign out_o.steer_command  = out_q.steer_command;
  assign out_o.beep_on        = out_q.beep_on;
  assign out_o.next_mode      = out_q.next_mode;
  assign out_o.shown_distance = out_q.shown_distance;

endmodule

@@ design/dsms_checker.sv @@
module dsms_checker import dsms_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ValW-1:0] motor_speed,
  input logic [1:0]      steer_command,
  input logic            beep_on,
  input logic [1:0]      next_mode,
  input logic [ValW-1:0] shown_distance
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable({motor_speed, steer_command, beep_on,
                                                      next_mode, shown_distance}))
    else $error("stalled result changed");

  // with no result pending the input side never blocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // no steering: either an idle tick or both sensors black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && steer_command == STEER_NONE |->
      (motor_speed == '0 && beep_on) || (!beep_on && next_mode == MODE_IDLE))
    else $error("inconsistent idle result");

  // turns sound the buzzer, forward does not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && steer_command != STEER_NONE |->
      (beep_on == (steer_command == STEER_RIGHT || steer_command == STEER_LEFT)))
    else $error("buzzer does not match steering");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> shown_distance <= ClampAbove || shown_distance == ClampValue)
    else $error("distance outside clamp");

endmodule

bind distance_speed_mode_steering_unit dsms_checker u_dsms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .motor_speed    (out_o.motor_speed),
  .steer_command  (out_o.steer_command),
  .beep_on        (out_o.beep_on),
  .next_mode      (out_o.next_mode),
  .shown_distance (out_o.shown_distance)
);
